@@ design/usbcts_pkg.sv @@
// Shared codes and constants for the USB control transfer sequencer.
`timescale 1ns / 1ps

package usbcts_pkg;

  // Transfer phases
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_SETUP  = 3'd1;
  localparam logic [2:0] PH_DIN    = 3'd2;
  localparam logic [2:0] PH_DOUT   = 3'd3;
  localparam logic [2:0] PH_STATUS = 3'd4;

  // Result actions
  localparam logic [1:0] ACT_SETUP = 2'd0;
  localparam logic [1:0] ACT_IN    = 2'd1;
  localparam logic [1:0] ACT_OUT   = 2'd2;
  localparam logic [1:0] ACT_DONE  = 2'd3;

  // Done codes
  localparam logic [1:0] DC_OK    = 2'd0;
  localparam logic [1:0] DC_ERR   = 2'd1;
  localparam logic [1:0] DC_STALL = 2'd2;
  localparam logic [1:0] DC_DISC  = 2'd3;

  // Token status codes
  localparam logic [2:0] TS_OK    = 3'd0;
  localparam logic [2:0] TS_NAK   = 3'd1;
  localparam logic [2:0] TS_STALL = 3'd2;
  localparam logic [2:0] TS_DISC  = 3'd3;

  // Kind of an input beat
  localparam logic REQ_START  = 1'b0;
  localparam logic REQ_RESULT = 1'b1;

  localparam logic [7:0] REQ_GET_DESC  = 8'd6;
  localparam logic       STATUS_TOGGLE = 1'b1;

  // Endpoint zero max packet size limits and reset value
  localparam logic [6:0] MPS_MIN   = 7'd8;
  localparam logic [6:0] MPS_MAX   = 7'd64;
  localparam logic [6:0] MPS_RESET = 7'd8;

  // Register address (byte address of the word)
  localparam logic ADDR_MPS = 1'b0;

endpackage

@@ design/usb_control_transfer_sequencer_unit.sv @@
// Top level of the USB host control transfer sequencer for endpoint zero.
`timescale 1ns / 1ps

// Usage:
//   The input channel (in_valid / in_stall) carries start beats (item_kind 0,
//   with the setup request fields) and token result beats (item_kind 1, with
//   token_status, packet_len, link_fail and read_fail). The output channel
//   (out_valid / out_stall) carries one result beat per input beat: the next
//   token to issue (SETUP, IN, OUT with its toggle and length) or a done
//   beat with its code and byte count. A result beat that arrives while the
//   transfer is idle produces no output.
//   The result is registered and appears in the cycle after its input
//   beat is taken. Throughput: one beat per cycle when not stalled; all
//   work for a beat is one pass of logic from the input ports to the
//   result register. When the receiver stalls, the result register holds
//   its beat and in_stall rises, so no further beat is taken until the
//   result drains. Reset (synchronous, active high) returns the transfer
//   to idle, empties the result register and sets max_packet_size back to 8.
//   The APB port holds max_packet_size at byte address 0; values below 8
//   act as 8 and values above 64 act as 64.
module usb_control_transfer_sequencer_unit
  import usbcts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        item_kind,
  input  logic [7:0]  request_type,
  input  logic [7:0]  request_code,
  input  logic [15:0] value,
  input  logic [15:0] index,
  input  logic [15:0] length,
  input  logic [2:0]  token_status,
  input  logic [6:0]  packet_len,
  input  logic        link_fail,
  input  logic        read_fail,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  action,
  output logic        toggle,
  output logic [6:0]  out_len,
  output logic [63:0] setup_packet,
  output logic        tolerant_retry,
  output logic [1:0]  done_code,
  output logic [15:0] xfer_len
);

  // Configuration register
  logic [6:0]  max_packet_size;
  logic [6:0]  mps;

  // Transfer state
  logic [2:0]  phase, phase_next;
  logic        seq_toggle, seq_toggle_next;
  logic [15:0] bytes_done, bytes_done_next;
  logic [15:0] bytes_wanted, bytes_wanted_next;
  logic        dir_in, dir_in_next;
  logic [6:0]  last_chunk, last_chunk_next;

  // Result beat under construction
  logic        res_valid;
  logic [1:0]  res_action;
  logic        res_toggle;
  logic [6:0]  res_out_len;
  logic [63:0] res_packet;
  logic        res_tolerant;
  logic [1:0]  res_done_code;
  logic [15:0] res_xfer_len;

  logic        accept;

  // Datapath helpers
  logic [15:0] rem_in;
  logic [6:0]  got;
  logic [15:0] done_in;
  logic [15:0] done_out;
  logic [15:0] rem_out;
  logic [15:0] rem_chunk;
  logic [6:0]  chunk;

  function automatic logic [1:0] fail_code(input logic [2:0] st);
    logic [1:0] dc;
    begin
      if (st == TS_DISC) begin
        dc = DC_DISC;
      end else if (st == TS_STALL) begin
        dc = DC_STALL;
      end else begin
        dc = DC_ERR;
      end
      return dc;
    end
  endfunction

  // APB: always ready, one register
  assign pready = 1'b1;
  assign prdata = {25'd0, max_packet_size};

  always_ff @(posedge clk) begin
    if (rst) begin
      max_packet_size <= MPS_RESET;
    end else if (psel && penable && pwrite && paddr[2] == ADDR_MPS) begin
      max_packet_size <= pwdata[6:0];
    end
  end

  // Clamp the configured size into the legal packet range
  always_comb begin
    if (max_packet_size < MPS_MIN) begin
      mps = MPS_MIN;
    end else if (max_packet_size > MPS_MAX) begin
      mps = MPS_MAX;
    end else begin
      mps = max_packet_size;
    end
  end

  // Take a beat whenever the result register is free or draining
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // IN data stage: received length saturates at the bytes still wanted
  assign rem_in  = bytes_wanted - bytes_done;
  assign got     = ({9'd0, packet_len} > rem_in) ? rem_in[6:0] : packet_len;
  assign done_in = bytes_done + {9'd0, got};

  // OUT chunking: from a start of data stage, or after the last chunk landed
  assign done_out  = bytes_done + {9'd0, last_chunk};
  assign rem_out   = bytes_wanted - done_out;
  assign rem_chunk = (phase == PH_DOUT) ? rem_out : bytes_wanted;
  assign chunk     = (rem_chunk > {9'd0, mps}) ? mps : rem_chunk[6:0];

  always_comb begin
    phase_next        = phase;
    seq_toggle_next   = seq_toggle;
    bytes_done_next   = bytes_done;
    bytes_wanted_next = bytes_wanted;
    dir_in_next       = dir_in;
    last_chunk_next   = last_chunk;

    res_valid     = 1'b0;
    res_action    = ACT_DONE;
    res_toggle    = 1'b0;
    res_out_len   = 7'd0;
    res_packet    = 64'd0;
    res_tolerant  = 1'b0;
    res_done_code = DC_OK;
    res_xfer_len  = 16'd0;

    if (item_kind == REQ_START) begin
      // Latch the request and issue SETUP
      dir_in_next       = request_type[7];
      bytes_wanted_next = length;
      bytes_done_next   = 16'd0;
      seq_toggle_next   = 1'b0;
      last_chunk_next   = 7'd0;
      phase_next        = PH_SETUP;
      res_valid         = 1'b1;
      res_action        = ACT_SETUP;
      res_packet        = {length, index, value, request_code, request_type};
      res_tolerant      = (request_code == REQ_GET_DESC);
    end else begin
      case (phase)
        PH_SETUP: begin
          res_valid = 1'b1;
          if (link_fail) begin
            phase_next    = PH_IDLE;
            res_done_code = DC_ERR;
          end else if (token_status != TS_OK) begin
            phase_next    = PH_IDLE;
            res_done_code = fail_code(token_status);
          end else begin
            seq_toggle_next = 1'b1;
            if (bytes_wanted == 16'd0) begin
              phase_next = PH_STATUS;
              res_action = dir_in ? ACT_OUT : ACT_IN;
              res_toggle = STATUS_TOGGLE;
            end else if (dir_in) begin
              phase_next = PH_DIN;
              res_action = ACT_IN;
              res_toggle = 1'b1;
            end else begin
              phase_next      = PH_DOUT;
              last_chunk_next = chunk;
              res_action      = ACT_OUT;
              res_toggle      = 1'b1;
              res_out_len     = chunk;
            end
          end
        end

        PH_DIN: begin
          res_valid = 1'b1;
          if (link_fail) begin
            phase_next    = PH_IDLE;
            res_done_code = DC_ERR;
          end else if (token_status == TS_NAK) begin
            // Re-issue the same IN token
            res_action = ACT_IN;
            res_toggle = seq_toggle;
          end else if (token_status == TS_STALL || token_status == TS_DISC) begin
            phase_next    = PH_IDLE;
            res_done_code = fail_code(token_status);
          end else if (token_status != TS_OK || read_fail) begin
            if (bytes_done != 16'd0) begin
              phase_next = PH_STATUS;
              res_action = ACT_OUT;
              res_toggle = STATUS_TOGGLE;
            end else begin
              phase_next    = PH_IDLE;
              res_done_code = DC_ERR;
            end
          end else begin
            if (got != 7'd0) begin
              bytes_done_next = done_in;
              seq_toggle_next = !seq_toggle;
            end
            // Short packet or everything received: go to status
            if (got < mps || done_in >= bytes_wanted) begin
              phase_next = PH_STATUS;
              res_action = ACT_OUT;
              res_toggle = STATUS_TOGGLE;
            end else begin
              res_action = ACT_IN;
              res_toggle = (got != 7'd0) ? !seq_toggle : seq_toggle;
            end
          end
        end

        PH_DOUT: begin
          res_valid = 1'b1;
          if (link_fail) begin
            phase_next    = PH_IDLE;
            res_done_code = DC_ERR;
          end else if (token_status != TS_OK) begin
            phase_next    = PH_IDLE;
            res_done_code = fail_code(token_status);
          end else begin
            bytes_done_next = done_out;
            seq_toggle_next = !seq_toggle;
            if (done_out < bytes_wanted) begin
              last_chunk_next = chunk;
              res_action      = ACT_OUT;
              res_toggle      = !seq_toggle;
              res_out_len     = chunk;
            end else begin
              phase_next = PH_STATUS;
              res_action = ACT_IN;
              res_toggle = STATUS_TOGGLE;
            end
          end
        end

        PH_STATUS: begin
          res_valid  = 1'b1;
          phase_next = PH_IDLE;
          if (link_fail || token_status != TS_OK) begin
            // IN transfer that already holds data counts as success
            if (dir_in && bytes_done != 16'd0) begin
              res_done_code = DC_OK;
            end else if (link_fail) begin
              res_done_code = DC_ERR;
            end else begin
              res_done_code = fail_code(token_status);
            end
          end else begin
            res_done_code = DC_OK;
          end
          if (res_done_code == DC_OK) begin
            res_xfer_len = bytes_done;
          end
        end

        default: begin
          // Result with no transfer open: drop it
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  // Transfer state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      seq_toggle   <= 1'b0;
      bytes_done   <= 16'd0;
      bytes_wanted <= 16'd0;
      dir_in       <= 1'b0;
      last_chunk   <= 7'd0;
    end else if (accept) begin
      phase        <= phase_next;
      seq_toggle   <= seq_toggle_next;
      bytes_done   <= bytes_done_next;
      bytes_wanted <= bytes_wanted_next;
      dir_in       <= dir_in_next;
      last_chunk   <= last_chunk_next;
    end
  end

  // Result register: load on accept, drop when taken and nothing new
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= res_valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      action         <= res_action;
      toggle         <= res_toggle;
      out_len        <= res_out_len;
      setup_packet   <= res_packet;
      tolerant_retry <= res_tolerant;
      done_code      <= res_done_code;
      xfer_len       <= res_xfer_len;
    end
  end

endmodule
